// ----- rtl/wsd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsd_pkg
// types and constants shared by the websocket frame deframer
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int FRAME_LEN_W = 17;
    localparam int MSG_LEN_W   = 18;
    localparam int CFG_DATA_W  = 18;

    localparam logic [FRAME_LEN_W-1:0] MAX_FRAME_LEN_RST = 17'h10000;
    localparam logic [MSG_LEN_W-1:0]   MAX_MSG_LEN_RST   = 18'h20000;

    localparam logic CFG_MAX_FRAME_LEN = 1'b0;
    localparam logic CFG_MAX_MSG_LEN   = 1'b1;

    localparam logic [1:0] EV_DATA      = 2'd0;
    localparam logic [1:0] EV_EMPTY_END = 2'd1;
    localparam logic [1:0] EV_CLOSE     = 2'd2;
    localparam logic [1:0] EV_OVERSIZE  = 2'd3;

    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    localparam logic [3:0] OPCODE_CLOSE = 4'h8;
    localparam logic [6:0] LEN7_EXT16  = 7'd126;
    localparam logic [6:0] LEN7_EXT64  = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [7:0] payload_byte;
        logic       message_last;
    } out_item_t;

    typedef struct packed {
        logic [FRAME_LEN_W-1:0] max_frame_len;
        logic [MSG_LEN_W-1:0]   max_message_len;
    } cfg_t;

endpackage

// ----- rtl/wsd_stream_if.sv -----
// ----------------------------------------------------------------------------
// wsd_stream_if
// valid/ready channel carrying one item of a given type
// ----------------------------------------------------------------------------
interface wsd_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/wsd_parser.sv -----
// ----------------------------------------------------------------------------
// wsd_parser
// frame parse state and per-byte result logic, one byte per enabled cycle
// ----------------------------------------------------------------------------
module wsd_parser
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output logic       res_valid,
    output out_item_t  res
);

    logic [2:0]             phase_reg, phase_next;
    logic                   fin_reg, fin_next;
    logic                   masked_reg, masked_next;
    logic [3:0]             left_reg, left_next;
    logic [MSG_LEN_W-1:0]   flen_reg, flen_next;
    logic                   ovf_reg, ovf_next;
    logic [31:0]            key_reg, key_next;
    logic [FRAME_LEN_W-1:0] pos_reg, pos_next;
    logic [MSG_LEN_W-1:0]   mtot_reg, mtot_next;
    logic                   halted_reg, halted_next;

    logic [MSG_LEN_W-1:0]   len_cand;
    logic                   ovf_cand;
    logic [MSG_LEN_W:0]     sum;
    logic                   too_big;
    logic [3:0]             left_dec;
    logic [FRAME_LEN_W-1:0] pos_inc;
    logic [7:0]             key_byte;

    always_comb
    begin
        left_dec = left_reg - 4'd1;
        pos_inc  = pos_reg + FRAME_LEN_W'(1);
        unique case (pos_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase

        if (phase_reg == PH_HDR1)
        begin
            len_cand = {11'd0, rx_byte[6:0]};
            ovf_cand = 1'b0;
        end
        else
        begin
            len_cand = {flen_reg[9:0], rx_byte};
            ovf_cand = ovf_reg || (flen_reg[17:10] != 8'd0);
        end
        sum     = {1'b0, mtot_reg} + {1'b0, len_cand};
        too_big = ovf_cand || (len_cand > {1'b0, cfg.max_frame_len})
                  || (sum > {1'b0, cfg.max_message_len});

        phase_next  = phase_reg;
        fin_next    = fin_reg;
        masked_next = masked_reg;
        left_next   = left_reg;
        flen_next   = flen_reg;
        ovf_next    = ovf_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        mtot_next   = mtot_reg;
        halted_next = halted_reg;
        res_valid   = 1'b0;
        res         = '{event_kind: EV_DATA, payload_byte: 8'd0, message_last: 1'b0};

        if (step && !halted_reg)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    fin_next = rx_byte[7];
                    if (rx_byte[3:0] == OPCODE_CLOSE)
                    begin
                        halted_next    = 1'b1;
                        res_valid      = 1'b1;
                        res.event_kind = EV_CLOSE;
                    end
                    else
                    begin
                        phase_next = PH_HDR1;
                    end
                end
                PH_HDR1, PH_EXTLEN:
                begin
                    if (phase_reg == PH_HDR1)
                    begin
                        masked_next = rx_byte[7];
                    end
                    ovf_next  = ovf_cand;
                    flen_next = len_cand;
                    if (phase_reg == PH_HDR1 && rx_byte[6:0] == LEN7_EXT16)
                    begin
                        left_next  = EXT16_BYTES;
                        flen_next  = '0;
                        phase_next = PH_EXTLEN;
                    end
                    else if (phase_reg == PH_HDR1 && rx_byte[6:0] == LEN7_EXT64)
                    begin
                        left_next  = EXT64_BYTES;
                        flen_next  = '0;
                        phase_next = PH_EXTLEN;
                    end
                    else if (phase_reg == PH_EXTLEN && left_dec != 4'd0)
                    begin
                        left_next = left_dec;
                    end
                    else
                    begin
                        left_next = (phase_reg == PH_EXTLEN) ? left_dec : left_reg;
                        if (too_big)
                        begin
                            halted_next    = 1'b1;
                            res_valid      = 1'b1;
                            res.event_kind = EV_OVERSIZE;
                        end
                        else
                        begin
                            mtot_next = sum[MSG_LEN_W-1:0];
                            key_next  = '0;
                            if (phase_reg == PH_HDR1 ? rx_byte[7] : masked_reg)
                            begin
                                left_next  = KEY_BYTES;
                                phase_next = PH_MASK;
                            end
                            else
                            begin
                                pos_next = '0;
                                if (len_cand == '0)
                                begin
                                    phase_next = PH_HDR0;
                                    if (fin_reg)
                                    begin
                                        mtot_next        = '0;
                                        res_valid        = 1'b1;
                                        res.event_kind   = EV_EMPTY_END;
                                        res.message_last = 1'b1;
                                    end
                                end
                                else
                                begin
                                    phase_next = PH_PAYLOAD;
                                end
                            end
                        end
                    end
                end
                PH_MASK:
                begin
                    key_next  = {key_reg[23:0], rx_byte};
                    left_next = left_dec;
                    if (left_dec == 4'd0)
                    begin
                        pos_next = '0;
                        if (flen_reg == '0)
                        begin
                            phase_next = PH_HDR0;
                            if (fin_reg)
                            begin
                                mtot_next        = '0;
                                res_valid        = 1'b1;
                                res.event_kind   = EV_EMPTY_END;
                                res.message_last = 1'b1;
                            end
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    pos_next         = pos_inc;
                    res_valid        = 1'b1;
                    res.payload_byte = rx_byte ^ key_byte;
                    if ({1'b0, pos_inc} >= flen_reg)
                    begin
                        phase_next = PH_HDR0;
                        if (fin_reg)
                        begin
                            res.message_last = 1'b1;
                            mtot_next        = '0;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            fin_reg    <= 1'b0;
            masked_reg <= 1'b0;
            left_reg   <= '0;
            flen_reg   <= '0;
            ovf_reg    <= 1'b0;
            key_reg    <= '0;
            pos_reg    <= '0;
            mtot_reg   <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            fin_reg    <= fin_next;
            masked_reg <= masked_next;
            left_reg   <= left_next;
            flen_reg   <= flen_next;
            ovf_reg    <= ovf_next;
            key_reg    <= key_next;
            pos_reg    <= pos_next;
            mtot_reg   <= mtot_next;
            halted_reg <= halted_next;
        end
    end

endmodule

// ----- rtl/websocket_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// receive-side websocket frame parser: header, extended length, mask key,
// unmasked payload bytes, close and oversize events
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | item
//  rx       | in  | rx_byte[7:0]                             | one received byte
//  events   | out | event_kind[1:0] payload_byte[7:0]        | zero or one per byte
//           |     | message_last                             |
//  cfg      | in  | cfg_we cfg_index cfg_wdata[17:0]         | limit register write
//
//  one byte per cycle sustained while events.ready stays high; a byte passes from the
//  input register through the parse logic into the result register, which drives the
//  events channel
//  rx.ready drops only while both registers hold items and events.ready is low
//  reset clears parse state and sets the limits to 65536 (frame) and 131072 (message)
//  after a close or oversize event all further bytes are dropped until reset
// ----------------------------------------------------------------------------
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    wsd_stream_if.sink            rx,
    wsd_stream_if.source          events
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    logic       advance;
    logic       step;
    logic       res_valid;
    out_item_t  res;

    assign advance      = !out_valid_reg || events.ready;
    assign step         = in_valid_reg && advance;
    assign rx.ready     = !in_valid_reg || advance;
    assign events.valid = out_valid_reg;
    assign events.data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_frame_len   <= MAX_FRAME_LEN_RST;
            cfg_reg.max_message_len <= MAX_MSG_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_FRAME_LEN: cfg_reg.max_frame_len   <= cfg_wdata[FRAME_LEN_W-1:0];
                CFG_MAX_MSG_LEN:   cfg_reg.max_message_len <= cfg_wdata[MSG_LEN_W-1:0];
                default:           cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx.ready)
            begin
                in_valid_reg <= rx.valid;
            end
            if (advance)
            begin
                out_valid_reg <= step && res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready)
        begin
            in_byte_reg <= rx.data.rx_byte;
        end
        if (advance)
        begin
            out_item_reg <= res;
        end
    end

    wsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

// ----- tb/sv/websocket_frame_deframer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_tb
// Self-checking bench for the websocket frame deframer. Bytes go in on the rx
// channel under random gaps, events are taken under random stalls, and every
// accepted byte runs through a cycle-free parser kept here, whose events are
// compared field by field with what the block emits. The run goes through
// several limit settings and ends on one randomly chosen stopping condition
// (close, frame too long, message too long, 64-bit length with top bit set).
// ----------------------------------------------------------------------------
import wsd_pkg::*;

class event_tracker;
    out_item_t              pending[$];
    logic [FRAME_LEN_W-1:0] frame_limit;
    logic [MSG_LEN_W-1:0]   message_limit;
    logic [2:0]             phase;
    bit                     fin;
    bit                     masked;
    logic [3:0]             bytes_left;
    logic [17:0]            frame_len;
    bit                     len_overflow;
    logic [31:0]            key;
    logic [16:0]            position;
    logic [17:0]            total;
    bit                     halted;
    int                     errors;
    int                     checked;
    int                     kind_count[4];

    function new();
        frame_limit   = MAX_FRAME_LEN_RST;
        message_limit = MAX_MSG_LEN_RST;
        phase         = PH_HDR0;
        fin           = 1'b0;
        masked        = 1'b0;
        bytes_left    = '0;
        frame_len     = '0;
        len_overflow  = 1'b0;
        key           = '0;
        position      = '0;
        total         = '0;
        halted        = 1'b0;
        errors        = 0;
        checked       = 0;
        kind_count    = '{default: 0};
    endfunction

    function void set_limits(logic [FRAME_LEN_W-1:0] frame_max,
                             logic [MSG_LEN_W-1:0] msg_max);
        frame_limit   = frame_max;
        message_limit = msg_max;
    endfunction

    // key read (or skipped): go to payload or close out an empty frame
    function bit enter_payload(output out_item_t ev);
        ev       = '0;
        position = '0;
        if (frame_len == '0) begin
            phase = PH_HDR0;
            if (fin) begin
                total           = '0;
                ev.event_kind   = EV_EMPTY_END;
                ev.message_last = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        end
        phase = PH_PAYLOAD;
        return 1'b0;
    endfunction

    function bit length_check(output out_item_t ev);
        logic [18:0] sum;
        ev  = '0;
        sum = total + frame_len;
        if (len_overflow || frame_len > frame_limit || sum > message_limit) begin
            halted        = 1'b1;
            ev.event_kind = EV_OVERSIZE;
            return 1'b1;
        end
        total = sum[17:0];
        key   = '0;
        if (masked) begin
            bytes_left = KEY_BYTES;
            phase      = PH_MASK;
            return 1'b0;
        end
        return enter_payload(ev);
    endfunction

    function bit deframe_byte(logic [7:0] b, output out_item_t ev);
        ev = '0;
        if (halted)
            return 1'b0;
        case (phase)
            PH_HDR0:
            begin
                fin = b[7];
                if (b[3:0] == OPCODE_CLOSE) begin
                    halted        = 1'b1;
                    ev.event_kind = EV_CLOSE;
                    return 1'b1;
                end
                phase = PH_HDR1;
                return 1'b0;
            end
            PH_HDR1:
            begin
                masked       = b[7];
                frame_len    = '0;
                len_overflow = 1'b0;
                if (b[6:0] == LEN7_EXT16) begin
                    bytes_left = EXT16_BYTES;
                    phase      = PH_EXTLEN;
                    return 1'b0;
                end
                if (b[6:0] == LEN7_EXT64) begin
                    bytes_left = EXT64_BYTES;
                    phase      = PH_EXTLEN;
                    return 1'b0;
                end
                frame_len = {11'd0, b[6:0]};
                return length_check(ev);
            end
            PH_EXTLEN:
            begin
                if (frame_len[17:10] != '0)
                    len_overflow = 1'b1;
                frame_len  = {frame_len[9:0], b};
                bytes_left = bytes_left - 4'd1;
                if (bytes_left != '0)
                    return 1'b0;
                return length_check(ev);
            end
            PH_MASK:
            begin
                key        = {key[23:0], b};
                bytes_left = bytes_left - 4'd1;
                if (bytes_left != '0)
                    return 1'b0;
                return enter_payload(ev);
            end
            PH_PAYLOAD:
            begin
                ev.event_kind   = EV_DATA;
                ev.payload_byte = b ^ key[8 * (3 - int'(position[1:0])) +: 8];
                position        = position + 17'd1;
                if ({1'b0, position} >= frame_len) begin
                    phase = PH_HDR0;
                    if (fin) begin
                        ev.message_last = 1'b1;
                        total           = '0;
                    end
                end
                return 1'b1;
            end
            default:
            begin
                phase = PH_HDR0;
                return 1'b0;
            end
        endcase
    endfunction

    function void note_byte(logic [7:0] b);
        out_item_t ev;
        if (deframe_byte(b, ev))
            pending.push_back(ev);
    endfunction

    function void check_event(out_item_t got);
        out_item_t want;
        checked++;
        kind_count[got.event_kind]++;
        if (pending.size() == 0) begin
            if (errors < 10)
                $display("%0t: unexpected event kind %0d byte %02h last %0b",
                         $time, got.event_kind, got.payload_byte, got.message_last);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.event_kind !== want.event_kind || got.payload_byte !== want.payload_byte
            || got.message_last !== want.message_last) begin
            if (errors < 10)
                $display("%0t: event mismatch: expected kind %0d byte %02h last %0b, %s",
                         $time, want.event_kind, want.payload_byte, want.message_last,
                         $sformatf("got kind %0d byte %02h last %0b",
                                   got.event_kind, got.payload_byte, got.message_last));
            errors++;
        end
    endfunction
endclass

module websocket_frame_deframer_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;

    typedef enum {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_e;
    typedef enum {STOP_CLOSE, STOP_FRAME_LIMIT, STOP_MESSAGE_LIMIT, STOP_LENGTH_TOP_BIT}
        stop_case_e;

    // opening frames: data extremes, masked empty end, empty fragment, ping,
    // 16-bit length, closing empty continuation
    localparam logic [7:0] OPENING_BYTES [26] = '{
        8'h81, 8'h02, 8'h00, 8'hFF,
        8'h82, 8'h80, 8'hA5, 8'h5A, 8'h0F, 8'hF0,
        8'h01, 8'h00,
        8'h89, 8'h81, 8'h12, 8'h34, 8'h56, 8'h78, 8'hFF,
        8'h7F, 8'h7E, 8'h00, 8'h01, 8'hAA,
        8'h80, 8'h00
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    wsd_stream_if #(.item_t(in_item_t))  rx_if ();
    wsd_stream_if #(.item_t(out_item_t)) ev_if ();

    websocket_frame_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rx        (rx_if.sink),
        .events    (ev_if.source)
    );

    event_tracker sb = new();

    int         cycle_count   = 0;
    int         bytes_sent    = 0;
    int         frames_sent   = 0;
    int         settings_used = 1;
    int         gap_pct       = 20;
    int         stall_pct     = 20;
    int         stall_left    = 0;
    stop_case_e stop_case     = STOP_CLOSE;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events still due",
                     cycle_count, sb.pending.size());
            $display("** websocket_frame_deframer: FAILED **");
            $finish;
        end
    end

    // event side: check each accepted item, stall in bursts
    initial
    begin
        ev_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (ev_if.valid === 1'b1 && ev_if.ready === 1'b1)
                sb.check_event(ev_if.data);
            if (stall_left > 0) begin
                stall_left--;
                ev_if.ready <= 1'b0;
            end
            else if (int'($urandom_range(0, 99)) < stall_pct) begin
                stall_left = int'($urandom_range(0, 6));
                ev_if.ready <= 1'b0;
            end
            else begin
                ev_if.ready <= 1'b1;
            end
        end
    end

    function automatic logic [3:0] data_opcode();
        logic [3:0] op;
        op = 4'($urandom_range(0, 15));
        if (op == OPCODE_CLOSE)
            op = 4'h0;
        return op;
    endfunction

    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = (int'($urandom_range(0, 99)) < gap_pct) ? int'($urandom_range(1, 7)) : 0;
        if (gap != 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.data  <= in_item_t'(value);
        do
            @(posedge clk);
        while (rx_if.ready !== 1'b1);
        sb.note_byte(value);
        bytes_sent++;
    endtask

    task automatic send_header(input bit fin, input logic [3:0] op, input bit masked,
                               input len_form_e form, input logic [63:0] len);
        send_byte({fin, 3'($urandom_range(0, 7)), op});
        case (form)
            FORM_SHORT:
                send_byte({masked, len[6:0]});
            FORM_EXT16:
            begin
                send_byte({masked, LEN7_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default:
            begin
                send_byte({masked, LEN7_EXT64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8 * i +: 8]);
            end
        endcase
    endtask

    task automatic send_frame(input bit fin, input logic [3:0] op, input bit masked,
                              input len_form_e form, input int len);
        send_header(fin, op, masked, form, 64'(len));
        if (masked)
            repeat (KEY_BYTES) send_byte(8'($urandom));
        repeat (len) send_byte(8'($urandom));
        frames_sent++;
    endtask

    // length stays within both limits so the parser never stops here
    task automatic random_frame();
        int        room;
        int        cap;
        int        len;
        int        pick;
        len_form_e form;
        room = int'(sb.message_limit) - int'(sb.total);
        cap  = (int'(sb.frame_limit) < room) ? int'(sb.frame_limit) : room;
        pick = int'($urandom_range(0, 99));
        if (pick < 70)
            len = int'($urandom_range(0, 12));
        else if (pick < 90)
            len = int'($urandom_range(13, 125));
        else if (pick < 98)
            len = int'($urandom_range(126, 300));
        else
            len = int'($urandom_range(301, 600));
        if (len > cap || (cap <= 600 && $urandom_range(0, 9) == 0))
            len = cap;
        if (len < 126) begin
            pick = int'($urandom_range(0, 9));
            form = (pick < 7) ? FORM_SHORT : (pick < 9) ? FORM_EXT16 : FORM_EXT64;
        end
        else begin
            form = ($urandom_range(0, 4) == 0) ? FORM_EXT64 : FORM_EXT16;
        end
        send_frame($urandom_range(0, 2) != 0, data_opcode(), 1'($urandom_range(0, 1)),
                   form, len);
    endtask

    task automatic drain(input int settle);
        rx_if.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // ends on an empty final frame so the running total is clear for new limits
    task automatic run_frames(input int target);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < target) begin
            random_frame();
            if ($urandom_range(0, 39) == 0)
                drain(SETTLE_CYCLES);
        end
        send_frame(1'b1, data_opcode(), 1'($urandom_range(0, 1)), FORM_SHORT, 0);
    endtask

    task automatic write_limits(input logic [FRAME_LEN_W-1:0] frame_max,
                                input logic [MSG_LEN_W-1:0] msg_max);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_FRAME_LEN;
        cfg_wdata <= CFG_DATA_W'(frame_max);
        @(posedge clk);
        cfg_index <= CFG_MAX_MSG_LEN;
        cfg_wdata <= msg_max;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_limits(frame_max, msg_max);
        settings_used++;
    endtask

    initial
    begin
        int frame_max;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_MAX_FRAME_LEN;
        cfg_wdata     = '0;
        rx_if.valid   = 1'b0;
        rx_if.data    = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (OPENING_BYTES[i])
            send_byte(OPENING_BYTES[i]);
        drain(SETTLE_CYCLES);

        write_limits(MAX_FRAME_LEN_RST, MAX_MSG_LEN_RST);
        gap_pct   = 15;
        stall_pct = 15;
        run_frames(300);
        drain(SETTLE_CYCLES);

        write_limits('0, '0);
        gap_pct   = 30;
        stall_pct = 0;
        run_frames(60);
        drain(SETTLE_CYCLES);

        frame_max = int'($urandom_range(1, 40));
        write_limits(FRAME_LEN_W'(frame_max), MSG_LEN_W'($urandom_range(frame_max, 100)));
        gap_pct   = 0;
        stall_pct = 30;
        run_frames(400);
        drain(SETTLE_CYCLES);

        write_limits(FRAME_LEN_W'($urandom_range(0, 65536)),
                     MSG_LEN_W'($urandom_range(0, 131072)));
        gap_pct   = 10;
        stall_pct = 10;
        run_frames(400);
        drain(SETTLE_CYCLES);

        // no random gaps or stalls from here on
        gap_pct   = 0;
        stall_pct = 0;
        run_frames(150);
        drain(SETTLE_CYCLES);

        stop_case = stop_case_e'($urandom_range(0, 3));
        case (stop_case)
            STOP_CLOSE:
                send_byte({1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), OPCODE_CLOSE});
            STOP_FRAME_LIMIT:
                send_header(1'($urandom_range(0, 1)), data_opcode(), 1'($urandom_range(0, 1)),
                            FORM_EXT64, 64'(sb.frame_limit) + 64'd1);
            STOP_MESSAGE_LIMIT:
            begin
                write_limits(FRAME_LEN_W'(16), MSG_LEN_W'(24));
                send_frame(1'b0, data_opcode(), 1'($urandom_range(0, 1)), FORM_SHORT, 16);
                send_header(1'($urandom_range(0, 1)), data_opcode(), 1'($urandom_range(0, 1)),
                            FORM_SHORT, 64'd9);
            end
            default:
                send_header(1'($urandom_range(0, 1)), data_opcode(), 1'($urandom_range(0, 1)),
                            FORM_EXT64, {1'b1, 31'($urandom), 32'($urandom)});
        endcase
        // parser is stopped, these must all be dropped
        repeat (16) send_byte(8'($urandom));
        drain(TAIL_CYCLES);

        if (sb.pending.size() != 0) begin
            $display("%0d expected events never arrived", sb.pending.size());
            sb.errors += sb.pending.size();
        end
        $display("run covered %0d bytes in %0d frames over %0d limit settings, stop case %s",
                 bytes_sent, frames_sent, settings_used, stop_case.name());
        $display("events checked %0d: data %0d, empty end %0d, close %0d, oversize %0d",
                 sb.checked, sb.kind_count[EV_DATA], sb.kind_count[EV_EMPTY_END],
                 sb.kind_count[EV_CLOSE], sb.kind_count[EV_OVERSIZE]);
        if (sb.errors == 0)
            $display("** websocket_frame_deframer: PASSED **");
        else
            $display("** websocket_frame_deframer: FAILED **");
        $finish;
    end

endmodule

// ----- websocket_frame_deframer.f -----
rtl/wsd_pkg.sv
rtl/wsd_stream_if.sv
rtl/wsd_parser.sv
rtl/websocket_frame_deframer.sv
tb/sv/websocket_frame_deframer_tb.sv
